>>> design/mcc_pkg.sv
package mcc_pkg;

    localparam int MAX_COINS_DEF  = 8;
    localparam int MAX_AMOUNT_DEF = 1024;

    localparam int FUNC_W  = 1;
    localparam int INDEX_W = 3;
    localparam int VALUE_W = 10;
    localparam int COUNT_W = 10;
    localparam int CFG_W   = 4;

    localparam int unsigned OUT_MAX = 1023;

    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [INDEX_W-1:0] coin_index;
        logic [VALUE_W-1:0] coin_value;
        logic [VALUE_W-1:0] target_amount;
    } in_t;

    typedef struct packed {
        logic [COUNT_W-1:0] min_coins;
        logic               reachable;
    } out_t;

endpackage

>>> design/mcc_ram.sv
module mcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/mcc_fill.sv
module mcc_fill #(
    parameter int MAX_COINS  = mcc_pkg::MAX_COINS_DEF,
    parameter int MAX_AMOUNT = mcc_pkg::MAX_AMOUNT_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  mcc_pkg::in_t              req_data,
    input  logic [mcc_pkg::CFG_W-1:0] coin_count,
    output logic                      res_valid,
    input  logic                      res_ready,
    output mcc_pkg::out_t             res_data
);

    localparam int AMT_W = $clog2(MAX_AMOUNT);
    localparam int CI_W  = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
    localparam int KC_W  = $clog2(MAX_COINS + 1);
    localparam int ENT_W = AMT_W + 1;
    localparam int CMP_W = (AMT_W > mcc_pkg::VALUE_W) ? AMT_W : mcc_pkg::VALUE_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t            state_reg;
    logic [AMT_W-1:0]  a_reg;
    logic [AMT_W-1:0]  tgt_reg;
    logic [KC_W-1:0]   k_reg;
    logic [KC_W-1:0]   used_reg;
    logic              p1_vld_reg;
    logic              p2_vld_reg;
    logic [AMT_W-1:0]  best_reg;
    logic              best_ok_reg;

    logic                        acc;
    logic                        is_query;
    logic                        oor;
    logic [KC_W-1:0]             used_next;
    logic                        coin_we;
    logic [CI_W-1:0]             coin_waddr;
    logic                        coin_re;
    logic [CI_W-1:0]             coin_raddr;
    logic [mcc_pkg::VALUE_W-1:0] coin_rdata;
    logic [CMP_W-1:0]            c_ext;
    logic [CMP_W-1:0]            a_ext;
    logic [CMP_W-1:0]            diff;
    logic                        hit1;
    logic                        dp_we;
    logic [AMT_W-1:0]            dp_waddr;
    logic [ENT_W-1:0]            dp_wdata;
    logic [AMT_W-1:0]            dp_raddr;
    logic [ENT_W-1:0]            dp_rdata;
    logic                        e_ok;
    logic [AMT_W-1:0]            cand;
    logic                        better;
    logic                        drained;

    assign req_ready = (state_reg == ST_IDLE);
    assign acc       = req_valid && req_ready;
    assign is_query  = (req_data.func == mcc_pkg::FUNC_QUERY);
    assign oor       = (32'(req_data.target_amount) >= 32'(MAX_AMOUNT));
    assign used_next = KC_W'((32'(coin_count) > 32'(MAX_COINS)) ?
                             32'(MAX_COINS) : 32'(coin_count));

    assign coin_we    = acc && !is_query && (32'(req_data.coin_index) < 32'(MAX_COINS));
    assign coin_waddr = CI_W'(req_data.coin_index);
    assign coin_re    = (state_reg == ST_ISSUE) && (k_reg < used_reg);
    assign coin_raddr = k_reg[CI_W-1:0];

    // stage 1: coin arrives, look up entry for amount minus coin
    assign c_ext    = CMP_W'(coin_rdata);
    assign a_ext    = CMP_W'(a_reg);
    assign diff     = a_ext - c_ext;
    assign hit1     = p1_vld_reg && (coin_rdata != '0) && (c_ext <= a_ext);
    assign dp_raddr = diff[AMT_W-1:0];

    // stage 2: fold candidate into running minimum
    assign e_ok   = dp_rdata[ENT_W-1];
    assign cand   = dp_rdata[AMT_W-1:0] + AMT_W'(1);
    assign better = p2_vld_reg && e_ok && (!best_ok_reg || (cand < best_reg));

    // write-back waits for the pipe to empty: no read of this entry is in flight
    assign drained  = !p1_vld_reg && !p2_vld_reg;
    assign dp_we    = (acc && is_query && !oor) || ((state_reg == ST_DRAIN) && drained);
    assign dp_waddr = (state_reg == ST_IDLE) ? '0 : a_reg;
    assign dp_wdata = (state_reg == ST_IDLE) ? {1'b1, AMT_W'(0)} : {best_ok_reg, best_reg};

    mcc_ram #(
        .WIDTH (mcc_pkg::VALUE_W),
        .DEPTH (MAX_COINS)
    ) u_coin_ram (
        .aclk    (aclk),
        .wr_en   (coin_we),
        .wr_addr (coin_waddr),
        .wr_data (req_data.coin_value),
        .rd_en   (coin_re),
        .rd_addr (coin_raddr),
        .rd_data (coin_rdata)
    );

    mcc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_AMOUNT)
    ) u_count_ram (
        .aclk    (aclk),
        .wr_en   (dp_we),
        .wr_addr (dp_waddr),
        .wr_data (dp_wdata),
        .rd_en   (hit1),
        .rd_addr (dp_raddr),
        .rd_data (dp_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
        end else begin
            p1_vld_reg <= coin_re;
            p2_vld_reg <= hit1;
            if (better) begin
                best_reg    <= cand;
                best_ok_reg <= 1'b1;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (acc && is_query) begin
                        used_reg <= used_next;
                        tgt_reg  <= AMT_W'(req_data.target_amount);
                        a_reg    <= AMT_W'(1);
                        k_reg    <= '0;
                        best_reg <= '0;
                        if (oor) begin
                            best_ok_reg <= 1'b0;
                            state_reg   <= ST_DONE;
                        end else if (req_data.target_amount == '0) begin
                            best_ok_reg <= 1'b1;
                            state_reg   <= ST_DONE;
                        end else begin
                            best_ok_reg <= 1'b0;
                            state_reg   <= ST_ISSUE;
                        end
                    end
                end
                ST_ISSUE: begin
                    if (coin_re) begin
                        k_reg <= k_reg + KC_W'(1);
                    end else begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (drained) begin
                        if (a_reg == tgt_reg) begin
                            state_reg <= ST_DONE;
                        end else begin
                            a_reg       <= a_reg + AMT_W'(1);
                            k_reg       <= '0;
                            best_ok_reg <= 1'b0;
                            state_reg   <= ST_ISSUE;
                        end
                    end
                end
                ST_DONE: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid          = (state_reg == ST_DONE);
    assign res_data.reachable = best_ok_reg;
    assign res_data.min_coins = !best_ok_reg ? '0 :
                                (32'(best_reg) > mcc_pkg::OUT_MAX) ?
                                mcc_pkg::COUNT_W'(mcc_pkg::OUT_MAX) :
                                mcc_pkg::COUNT_W'(best_reg);

endmodule

>>> design/min_coin_change_dp.sv
// Minimum coin change. A load beat (func 0) writes one denomination into the
// coin RAM. A query beat (func 1) rebuilds the count RAM from amount 1 up to
// the target and answers with the least coin count and a reachable flag. For
// each amount it tries one coin per cycle through the coin RAM and count RAM
// read pipeline, then lets the pipeline drain and writes the new entry back
// before the next amount may read it. Queries at or above MAX_AMOUNT, and
// target zero, skip the fill: the first answer unreachable, the second zero.
// A finished result sits in the output register, so the next beat is taken
// while it waits. The user must write coin_count (cfg_data) only while the
// block is idle; the block itself does not enforce this.
module min_coin_change_dp #(
    parameter int MAX_COINS  = mcc_pkg::MAX_COINS_DEF,
    parameter int MAX_AMOUNT = mcc_pkg::MAX_AMOUNT_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  mcc_pkg::in_t              s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output mcc_pkg::out_t             m_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [mcc_pkg::CFG_W-1:0] cfg_data
);

    logic [mcc_pkg::CFG_W-1:0] coin_count_reg;
    logic                      m_valid_reg;
    mcc_pkg::out_t             m_data_reg;

    logic          res_valid;
    logic          res_ready;
    mcc_pkg::out_t res_data;

    assign cfg_ready = 1'b1;
    assign res_ready = !m_valid_reg || m_ready;

    mcc_fill #(
        .MAX_COINS  (MAX_COINS),
        .MAX_AMOUNT (MAX_AMOUNT)
    ) u_fill (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (s_valid),
        .req_ready  (s_ready),
        .req_data   (s_data),
        .coin_count (coin_count_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coin_count_reg <= mcc_pkg::CFG_W'(1);
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                coin_count_reg <= cfg_data;
            end
            if (res_valid && res_ready) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= res_data;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> design/mcc_checker.sv
module mcc_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input mcc_pkg::in_t  s_data,
    input logic          m_valid,
    input logic          m_ready,
    input mcc_pkg::out_t m_data
);

    // result beat holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // a query keeps the block busy for at least the next cycle
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.func == mcc_pkg::FUNC_QUERY) |=> !s_ready)
        else $error("input taken right after a query");

    // after a load the input is ready again in the next cycle
    a_load_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.func == mcc_pkg::FUNC_LOAD) |=> s_ready)
        else $error("input stalled after a load");

    // unreachable result carries a zero count
    a_unreach_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.reachable |-> (m_data.min_coins == '0))
        else $error("unreachable result with nonzero count");

endmodule

bind min_coin_change_dp mcc_checker u_mcc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
